>>> hw/rtl/tmsf_pkg.sv
// Shared types and constants for the trimmed-mean smoothing filter.
// No dependencies; tmsf_back and the top level refer to it by scoped names.
package tmsf_pkg;

  localparam int unsigned CFG_W = 5;
  localparam logic [CFG_W-1:0] WINDOW_RESET = 5'd8;
  localparam int unsigned WINDOW_MIN = 3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TRIM,
    ST_DIV1,
    ST_MID,
    ST_DIV2,
    ST_OUT
  } back_state_t;

endpackage

>>> hw/rtl/tmsf_front.sv
// Input side of the filter: accepts sample transfers into a two-entry queue.
// Depends on nothing beyond the clock and reset.
module tmsf_front #(
  parameter int unsigned SW = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [SW-1:0] in_sample,
  output logic                 q_valid,
  output logic signed [SW-1:0] q_data,
  input  logic                 q_pop
);

  logic signed [SW-1:0] entry_r [2];
  logic                 wr_ptr_r, wr_ptr_nxt;
  logic                 rd_ptr_r, rd_ptr_nxt;
  logic [1:0]           count_r, count_nxt;
  logic                 push;
  logic                 pop;

  assign in_ready = (count_r != 2'd2);
  assign q_valid  = (count_r != 2'd0);
  assign q_data   = entry_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= in_sample;
    end
  end

endmodule

>>> hw/rtl/tmsf_divider.sv
// Iterative signed divider by a small unsigned divisor, two quotient bits a cycle.
// Truncates toward zero. No package dependencies.
module tmsf_divider #(
  parameter int unsigned DW = 29,
  parameter int unsigned NW = 5
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [DW-1:0] dividend,
  input  logic [NW-1:0]        divisor,
  output logic                 done,
  output logic signed [DW-1:0] quotient
);

  localparam int unsigned DWE  = DW + (DW % 2);
  localparam int unsigned ITER = DWE / 2;
  localparam int unsigned CW   = $clog2(ITER + 1);

  logic [DWE-1:0] quo_r, quo_nxt;
  logic [NW-1:0]  rem_r, rem_nxt;
  logic [NW-1:0]  div_r;
  logic           neg_r;
  logic           busy_r;
  logic           done_r;
  logic [CW-1:0]  cnt_r;
  logic [DWE-1:0] dividend_ext;
  logic [DWE-1:0] quo_signed;

  assign dividend_ext = DWE'(dividend);
  assign quo_signed   = neg_r ? (~quo_r + DWE'(1)) : quo_r;
  assign quotient     = quo_signed[DW-1:0];
  assign done         = done_r;

  always_comb begin
    logic [NW:0]    t;
    logic [NW-1:0]  r;
    logic [DWE-1:0] q;
    r = rem_r;
    q = quo_r;
    for (int k = 0; k < 2; k++) begin
      t = {r, q[DWE-1]};
      q = {q[DWE-2:0], 1'b0};
      if (t >= {1'b0, div_r}) begin
        t    = t - {1'b0, div_r};
        q[0] = 1'b1;
      end
      r = t[NW-1:0];
    end
    rem_nxt = r;
    quo_nxt = q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(ITER);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend_ext[DWE-1];
      quo_r <= dividend_ext[DWE-1] ? (~dividend_ext + DWE'(1)) : dividend_ext;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

endmodule

>>> hw/rtl/tmsf_back.sv
// Execution side: window stores, scan sequencer, the two divisions and the result register.
// Depends on tmsf_pkg and tmsf_divider.
module tmsf_back #(
  parameter int unsigned SW = 16,
  parameter int unsigned FB = 8,
  parameter int unsigned WM = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [tmsf_pkg::CFG_W-1:0]   window_length,
  input  logic                         q_valid,
  input  logic signed [SW-1:0]         q_data,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [SW+FB-1:0]             out_data
);

  localparam int unsigned TW    = SW + FB;
  localparam int unsigned DEPTH = WM - 1;
  localparam int unsigned LG    = $clog2(WM);
  localparam int unsigned SUM_W = SW + LG + 1;
  localparam int unsigned DW    = SW + FB + LG + 1;
  localparam int unsigned NW    = $clog2(WM + 1);
  localparam int unsigned IW    = $clog2(DEPTH);
  localparam int unsigned LW    = (NW > tmsf_pkg::CFG_W) ? NW : tmsf_pkg::CFG_W;

  tmsf_pkg::back_state_t state_r, state_nxt;

  logic signed [SW-1:0]    sw_r [DEPTH];
  logic signed [TW-1:0]    tw_r [DEPTH];
  logic signed [SW-1:0]    x_r;
  logic signed [SW-1:0]    hi_r;
  logic signed [SW-1:0]    lo_r;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [DW-1:0]    tsum_r;
  logic signed [TW-1:0]    trim_r;
  logic signed [TW-1:0]    res_r;
  logic [IW-1:0]           idx_r;
  logic [NW-1:0]           n_r;
  logic [NW-1:0]           n_eff;
  logic [LW-1:0]           wl_ext;
  logic signed [DW-1:0]    div_a_r;
  logic [NW-1:0]           div_b_r;
  logic                    div_go_r;
  logic                    div_done;
  logic signed [DW-1:0]    div_q;
  logic                    out_valid_r;
  logic [TW-1:0]           out_data_r;
  logic                    scan_last;
  logic                    load_out;
  logic signed [SW-1:0]    scan_v;
  logic signed [TW-1:0]    scan_t;
  logic signed [SUM_W-1:0] trim_sum;

  assign wl_ext = LW'(window_length);

  always_comb begin
    if (wl_ext < LW'(tmsf_pkg::WINDOW_MIN)) begin
      n_eff = NW'(tmsf_pkg::WINDOW_MIN);
    end else if (wl_ext > LW'(WM)) begin
      n_eff = NW'(WM);
    end else begin
      n_eff = NW'(wl_ext);
    end
  end

  assign scan_v    = sw_r[idx_r];
  assign scan_t    = tw_r[idx_r];
  assign scan_last = (idx_r == IW'(n_r - NW'(2)));
  assign trim_sum  = sum_r - SUM_W'(hi_r) - SUM_W'(lo_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tmsf_pkg::ST_IDLE: if (q_valid) state_nxt = tmsf_pkg::ST_SCAN;
      tmsf_pkg::ST_SCAN: if (scan_last) state_nxt = tmsf_pkg::ST_TRIM;
      tmsf_pkg::ST_TRIM: state_nxt = tmsf_pkg::ST_DIV1;
      tmsf_pkg::ST_DIV1: if (div_done) state_nxt = tmsf_pkg::ST_MID;
      tmsf_pkg::ST_MID:  state_nxt = tmsf_pkg::ST_DIV2;
      tmsf_pkg::ST_DIV2: if (div_done) state_nxt = tmsf_pkg::ST_OUT;
      tmsf_pkg::ST_OUT:  if (!out_valid_r || out_ready) state_nxt = tmsf_pkg::ST_IDLE;
      default:           state_nxt = tmsf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    load_out = 1'b0;
    unique case (state_r)
      tmsf_pkg::ST_IDLE: q_pop = q_valid;
      tmsf_pkg::ST_OUT:  load_out = !out_valid_r || out_ready;
      default: begin
        q_pop    = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tmsf_pkg::ST_IDLE;
      div_go_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
        sw_r[i] <= '0;
        tw_r[i] <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      div_go_r <= (state_r == tmsf_pkg::ST_TRIM) || (state_r == tmsf_pkg::ST_MID);
      if (load_out) begin
        out_valid_r <= 1'b1;
        sw_r[0]     <= x_r;
        tw_r[0]     <= trim_r;
        for (int i = 1; i < DEPTH; i++) begin
          sw_r[i] <= sw_r[i-1];
          tw_r[i] <= tw_r[i-1];
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      tmsf_pkg::ST_IDLE: begin
        x_r    <= q_data;
        hi_r   <= q_data;
        lo_r   <= q_data;
        sum_r  <= SUM_W'(q_data);
        tsum_r <= '0;
        idx_r  <= '0;
        n_r    <= n_eff;
      end
      tmsf_pkg::ST_SCAN: begin
        sum_r  <= sum_r + SUM_W'(scan_v);
        tsum_r <= tsum_r + DW'(scan_t);
        if (scan_v > hi_r) hi_r <= scan_v;
        if (scan_v < lo_r) lo_r <= scan_v;
        idx_r <= idx_r + IW'(1);
      end
      tmsf_pkg::ST_TRIM: begin
        div_a_r <= DW'(trim_sum) <<< FB;
        div_b_r <= n_r - NW'(2);
      end
      tmsf_pkg::ST_DIV1: if (div_done) trim_r <= div_q[TW-1:0];
      tmsf_pkg::ST_MID: begin
        div_a_r <= tsum_r + DW'(trim_r);
        div_b_r <= n_r;
      end
      tmsf_pkg::ST_DIV2: if (div_done) res_r <= div_q[TW-1:0];
      tmsf_pkg::ST_OUT:  if (load_out) out_data_r <= res_r;
      default: ;
    endcase
  end

  tmsf_divider #(
    .DW (DW),
    .NW (NW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go_r),
    .dividend (div_a_r),
    .divisor  (div_b_r),
    .done     (div_done),
    .quotient (div_q)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> hw/rtl/trimmed_mean_smoothing_filter_unit.sv
// Top level of the trimmed-mean smoothing filter.
// Depends on tmsf_pkg, tmsf_front, tmsf_back and tmsf_divider.
//
// Usage:
//   in_*  : one signed sample per transfer, tdata bits [SAMPLE_WIDTH-1:0].
//   out_* : one filtered value per sample, signed, FRACTION_BITS fraction
//           bits, tdata bits [SAMPLE_WIDTH+FRACTION_BITS-1:0], rest zero.
//   cfg_* : cfg_wen writes cfg_wdata into the window length N (3..WINDOW_MAX,
//           clamped); write only while the block holds no sample.
// Each sample goes from the queue head to the result register through a
// window scan, one stored sample per cycle, then two divisions on a shared
// divider that settles two quotient bits a cycle. One sample is worked on at
// a time; a two-entry input queue and the result register take further
// transfers meanwhile.
// Reset clears both windows to zero, sets N to 8 and empties the queue.
// When out_tready is low the result holds and, once queue and result register
// are full, in_tready falls.
module trimmed_mean_smoothing_filter_unit #(
  parameter int unsigned WINDOW_MAX    = 16,
  parameter int unsigned SAMPLE_WIDTH  = 16,
  parameter int unsigned FRACTION_BITS = 8
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         in_tvalid,
  output logic                                         in_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]            in_tdata,   // sample
  output logic                                         out_tvalid,
  input  logic                                         out_tready,
  output logic [((SAMPLE_WIDTH+FRACTION_BITS+7)/8)*8-1:0] out_tdata, // filtered
  input  logic                                         cfg_wen,
  input  logic [tmsf_pkg::CFG_W-1:0]                   cfg_wdata
);

  localparam int unsigned TW    = SAMPLE_WIDTH + FRACTION_BITS;
  localparam int unsigned OUT_W = ((TW + 7) / 8) * 8;

  logic [tmsf_pkg::CFG_W-1:0]     window_length_r;
  logic                           q_valid;
  logic signed [SAMPLE_WIDTH-1:0] q_data;
  logic                           q_pop;
  logic [TW-1:0]                  filtered;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_length_r <= tmsf_pkg::WINDOW_RESET;
    end else if (cfg_wen) begin
      window_length_r <= cfg_wdata;
    end
  end

  tmsf_front #(
    .SW (SAMPLE_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_sample (in_tdata[SAMPLE_WIDTH-1:0]),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop)
  );

  tmsf_back #(
    .SW (SAMPLE_WIDTH),
    .FB (FRACTION_BITS),
    .WM (WINDOW_MAX)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .window_length (window_length_r),
    .q_valid       (q_valid),
    .q_data        (q_data),
    .q_pop         (q_pop),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_data      (filtered)
  );

  assign out_tdata = OUT_W'(filtered);

endmodule

>>> hw/rtl/tmsf_checker.sv
// Port-level checks for the trimmed-mean smoothing filter, bound to the top level.
// Depends on trimmed_mean_smoothing_filter_unit.
module tmsf_checker #(
  parameter int unsigned SAMPLE_WIDTH  = 16,
  parameter int unsigned FRACTION_BITS = 8
) (
  input logic                                            clk,
  input logic                                            rst_n,
  input logic                                            in_tvalid,
  input logic                                            in_tready,
  input logic                                            out_tvalid,
  input logic                                            out_tready,
  input logic [((SAMPLE_WIDTH+FRACTION_BITS+7)/8)*8-1:0] out_tdata
);

  logic [3:0] in_flight_r;
  logic       in_xfer;
  logic       out_xfer;

  assign in_xfer  = in_tvalid && in_tready;
  assign out_xfer = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_flight_r <= 4'd0;
    end else if (in_xfer && !out_xfer) begin
      in_flight_r <= in_flight_r + 4'd1;
    end else if (out_xfer && !in_xfer) begin
      in_flight_r <= in_flight_r - 4'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed or dropped while stalled");

  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_tvalid)
    else $error("result presented straight after reset");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> in_flight_r != 4'd0)
    else $error("result without an outstanding sample");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    in_flight_r <= 4'd4)
    else $error("more samples held than queue and stages allow");

endmodule

bind trimmed_mean_smoothing_filter_unit tmsf_checker #(
  .SAMPLE_WIDTH  (SAMPLE_WIDTH),
  .FRACTION_BITS (FRACTION_BITS)
) u_tmsf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
